>>> src/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is low.
`define CHK_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, live through reset as well.
`define CHK_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/pps_pkg.sv
`timescale 1ns / 1ps
package pps_pkg;
    localparam int CoordW   = 32;
    localparam int FracB    = 16;
    localparam int AspectW  = 16;
    localparam int TanW     = 24;
    localparam int CfgIdxW  = 8;
    localparam int CfgDataW = 24;

    localparam int NumShift = 2 * FracB - 8;
    localparam int ProdW    = AspectW + CoordW;
    localparam int NumW     = ProdW + NumShift;
    localparam int SW       = CoordW + TanW;
    localparam int DivW     = SW + CoordW;
    localparam int QW       = CoordW + 1;

    localparam logic [SW-1:0]      DeltaRaw  = SW'((64'd1 << (2 * FracB)) / 64'd1000);
    localparam logic [AspectW-1:0] AspectOne = AspectW'(256);
    localparam logic [AspectW-1:0] AspectRst = AspectW'(256);
    localparam logic [TanW-1:0]    TanRst    = TanW'(64'd1 << FracB);

    typedef enum logic [CfgIdxW-1:0] {
        REG_ASPECT = 8'd0,
        REG_TAN    = 8'd1
    } t_cfg_reg;

    typedef logic signed [CoordW-1:0] t_coord;

    // One word in flight through the divider.
    typedef struct packed {
        logic [NumW-1:0] rem_x;
        logic [NumW-1:0] rem_y;
        logic [DivW-1:0] div;
        logic [QW-1:0]   q_x;
        logic [QW-1:0]   q_y;
        logic            neg_x;
        logic            neg_y;
        logic            big_x;
        logic            big_y;
        logic            inv;
    } t_div_item;
endpackage

>>> src/pps_if.sv
`timescale 1ns / 1ps
interface pps_in_if;
    logic                 valid;
    logic                 ready;
    pps_pkg::t_coord      point_x;
    pps_pkg::t_coord      point_y;
    pps_pkg::t_coord      point_z;
    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface pps_out_if;
    logic                 valid;
    logic                 ready;
    pps_pkg::t_coord      screen_x;
    pps_pkg::t_coord      screen_y;
    logic                 invalid;
    logic                 overflow;
    modport source (output valid, screen_x, screen_y, invalid, overflow, input ready);
    modport sink   (input valid, screen_x, screen_y, invalid, overflow, output ready);
endinterface

interface pps_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pps_pkg::CfgIdxW-1:0]     index;
    logic [pps_pkg::CfgDataW-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/perspective_project_screen_core.sv
`timescale 1ns / 1ps
// Perspective projection with z-divide. Takes one point (x, y, z, signed Q16.16) per cycle
// and returns screen_x = aspect*x/(z*tan) and screen_y = y/(z*tan), truncated toward zero and
// saturated to Q16.16 (overflow flag), or zeros with the invalid flag when |z*tan| <= 0.001.
// The pipe has three front stages (sign/magnitude, multiplies, range checks), one
// restoring-divider stage per quotient bit (33, x and y in parallel lanes), one output stage.
// Throughput is one word per cycle; a stall on the output freezes the whole pipe.
// Registers: index 0 horizontal aspect scale (Q8.8, reset 1.0), index 1 tan_half_fov
// (Q8.16, reset 1.0); write only while idle, other indexes are ignored.
module perspective_project_screen_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pps_in_if.sink      i_pt,
    pps_cfg_if.sink     i_cfg,
    pps_out_if.source   o_scr
);
    localparam int Steps = pps_pkg::QW;

    logic [pps_pkg::AspectW-1:0] r_aspect;
    logic [pps_pkg::TanW-1:0]    r_tan;
    logic                        ce;
    logic                        out_v;

    logic                        v_chain [Steps+1];
    pps_pkg::t_div_item          d_chain [Steps+1];

    assign ce          = !out_v || o_scr.ready;
    assign i_pt.ready  = ce;
    assign i_cfg.ready = 1'b1;
    assign o_scr.valid = out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aspect <= pps_pkg::AspectRst;
            r_tan    <= pps_pkg::TanRst;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                pps_pkg::REG_ASPECT: r_aspect <= i_cfg.data[pps_pkg::AspectW-1:0];
                pps_pkg::REG_TAN:    r_tan    <= i_cfg.data[pps_pkg::TanW-1:0];
                default: ;
            endcase
        end
    end

    pps_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (i_pt.valid),
        .i_x     (i_pt.point_x),
        .i_y     (i_pt.point_y),
        .i_z     (i_pt.point_z),
        .i_aspect(r_aspect),
        .i_tan   (r_tan),
        .o_valid (v_chain[0]),
        .o_item  (d_chain[0])
    );

    for (genvar g = 0; g < Steps; g++) begin : g_div
        pps_div_step u_step (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ce   (ce),
            .i_valid(v_chain[g]),
            .i_item (d_chain[g]),
            .o_valid(v_chain[g+1]),
            .o_item (d_chain[g+1])
        );
    end

    pps_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ce      (ce),
        .i_valid   (v_chain[Steps]),
        .i_item    (d_chain[Steps]),
        .o_valid   (out_v),
        .o_sx      (o_scr.screen_x),
        .o_sy      (o_scr.screen_y),
        .o_invalid (o_scr.invalid),
        .o_overflow(o_scr.overflow)
    );
endmodule

>>> src/pps_front.sv
`timescale 1ns / 1ps
module pps_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_ce,
    input  logic                          i_valid,
    input  pps_pkg::t_coord               i_x,
    input  pps_pkg::t_coord               i_y,
    input  pps_pkg::t_coord               i_z,
    input  logic [pps_pkg::AspectW-1:0]   i_aspect,
    input  logic [pps_pkg::TanW-1:0]      i_tan,
    output logic                          o_valid,
    output pps_pkg::t_div_item            o_item
);
    // stage 1: sign/magnitude
    logic                          r1_v;
    logic [pps_pkg::CoordW-1:0]    r1_mx, r1_my, r1_mz;
    logic                          r1_nx, r1_ny;
    // stage 2: products
    logic                          r2_v;
    logic [pps_pkg::SW-1:0]        r2_s;
    logic [pps_pkg::ProdW-1:0]     r2_px, r2_py;
    logic                          r2_nx, r2_ny;
    // stage 3: range checks
    logic                          r3_v;
    pps_pkg::t_div_item            r3_item;

    logic [pps_pkg::CoordW-1:0]    n1_mx, n1_my, n1_mz;
    logic [pps_pkg::NumW-1:0]      n3_num_x, n3_num_y;
    logic [pps_pkg::DivW:0]        n3_lim;

    assign n1_mx = i_x[pps_pkg::CoordW-1] ? (~i_x + 1'b1) : i_x;
    assign n1_my = i_y[pps_pkg::CoordW-1] ? (~i_y + 1'b1) : i_y;
    assign n1_mz = i_z[pps_pkg::CoordW-1] ? (~i_z + 1'b1) : i_z;

    assign n3_num_x = {r2_px, {pps_pkg::NumShift{1'b0}}};
    assign n3_num_y = {r2_py, {pps_pkg::NumShift{1'b0}}};
    // quotient would reach 2^(W+1): saturated regardless of the low bits
    assign n3_lim   = {r2_s, {(pps_pkg::CoordW + 1){1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_ce) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_mx <= n1_mx;
            r1_my <= n1_my;
            r1_mz <= n1_mz;
            r1_nx <= i_x[pps_pkg::CoordW-1] ^ i_z[pps_pkg::CoordW-1];
            r1_ny <= i_y[pps_pkg::CoordW-1] ^ i_z[pps_pkg::CoordW-1];

            r2_s  <= r1_mz * i_tan;
            r2_px <= i_aspect * r1_mx;
            r2_py <= pps_pkg::AspectOne * r1_my;
            r2_nx <= r1_nx;
            r2_ny <= r1_ny;

            r3_item.rem_x <= n3_num_x;
            r3_item.rem_y <= n3_num_y;
            r3_item.div   <= {r2_s, {pps_pkg::CoordW{1'b0}}};
            r3_item.q_x   <= '0;
            r3_item.q_y   <= '0;
            r3_item.neg_x <= r2_nx;
            r3_item.neg_y <= r2_ny;
            r3_item.big_x <= {{(pps_pkg::DivW + 1 - pps_pkg::NumW){1'b0}}, n3_num_x} >= n3_lim;
            r3_item.big_y <= {{(pps_pkg::DivW + 1 - pps_pkg::NumW){1'b0}}, n3_num_y} >= n3_lim;
            r3_item.inv   <= r2_s <= pps_pkg::DeltaRaw;
        end
    end

    assign o_valid = r3_v;
    assign o_item  = r3_item;
endmodule

>>> src/pps_div_step.sv
`timescale 1ns / 1ps
module pps_div_step (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_ce,
    input  logic                 i_valid,
    input  pps_pkg::t_div_item   i_item,
    output logic                 o_valid,
    output pps_pkg::t_div_item   o_item
);
    logic                        r_v;
    pps_pkg::t_div_item          r_item;
    pps_pkg::t_div_item          n_item;
    logic                        ge_x, ge_y;
    logic [pps_pkg::DivW-1:0]    ext_x, ext_y;

    // restoring step: divisor pre-shifted, moves right one bit per stage
    assign ext_x = {{(pps_pkg::DivW - pps_pkg::NumW){1'b0}}, i_item.rem_x};
    assign ext_y = {{(pps_pkg::DivW - pps_pkg::NumW){1'b0}}, i_item.rem_y};
    assign ge_x  = ext_x >= i_item.div;
    assign ge_y  = ext_y >= i_item.div;

    always_comb begin
        n_item       = i_item;
        n_item.rem_x = ge_x ? pps_pkg::NumW'(ext_x - i_item.div) : i_item.rem_x;
        n_item.rem_y = ge_y ? pps_pkg::NumW'(ext_y - i_item.div) : i_item.rem_y;
        n_item.q_x   = {i_item.q_x[pps_pkg::QW-2:0], ge_x};
        n_item.q_y   = {i_item.q_y[pps_pkg::QW-2:0], ge_y};
        n_item.div   = i_item.div >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_ce) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_v;
    assign o_item  = r_item;
endmodule

>>> src/pps_back.sv
`timescale 1ns / 1ps
module pps_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_ce,
    input  logic                 i_valid,
    input  pps_pkg::t_div_item   i_item,
    output logic                 o_valid,
    output pps_pkg::t_coord      o_sx,
    output pps_pkg::t_coord      o_sy,
    output logic                 o_invalid,
    output logic                 o_overflow
);
    localparam logic [pps_pkg::QW-1:0] QPosMax =
        {2'b00, {(pps_pkg::CoordW - 1){1'b1}}};
    localparam logic [pps_pkg::QW-1:0] QNegMax =
        {2'b01, {(pps_pkg::CoordW - 1){1'b0}}};
    localparam logic [pps_pkg::CoordW-1:0] OutMax = {1'b0, {(pps_pkg::CoordW - 1){1'b1}}};
    localparam logic [pps_pkg::CoordW-1:0] OutMin = {1'b1, {(pps_pkg::CoordW - 1){1'b0}}};

    logic                        r_v;
    pps_pkg::t_coord             r_sx, r_sy;
    logic                        r_inv, r_ovf;
    logic [pps_pkg::CoordW-1:0]  n_sx, n_sy;
    logic                        sat_x, sat_y;

    always_comb begin
        sat_x = i_item.big_x || (i_item.neg_x ? (i_item.q_x > QNegMax) : (i_item.q_x > QPosMax));
        sat_y = i_item.big_y || (i_item.neg_y ? (i_item.q_y > QNegMax) : (i_item.q_y > QPosMax));
        if (sat_x) begin
            n_sx = i_item.neg_x ? OutMin : OutMax;
        end else begin
            n_sx = i_item.neg_x ? (~i_item.q_x[pps_pkg::CoordW-1:0] + 1'b1)
                                : i_item.q_x[pps_pkg::CoordW-1:0];
        end
        if (sat_y) begin
            n_sy = i_item.neg_y ? OutMin : OutMax;
        end else begin
            n_sy = i_item.neg_y ? (~i_item.q_y[pps_pkg::CoordW-1:0] + 1'b1)
                                : i_item.q_y[pps_pkg::CoordW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_ce) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_sx  <= i_item.inv ? '0 : n_sx;
            r_sy  <= i_item.inv ? '0 : n_sy;
            r_inv <= i_item.inv;
            r_ovf <= !i_item.inv && (sat_x || sat_y);
        end
    end

    assign o_valid    = r_v;
    assign o_sx       = r_sx;
    assign o_sy       = r_sy;
    assign o_invalid  = r_inv;
    assign o_overflow = r_ovf;
endmodule

>>> src/pps_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pps_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  pps_pkg::t_coord  i_sx,
    input  pps_pkg::t_coord  i_sy,
    input  logic             i_invalid,
    input  logic             i_overflow
);
    logic [pps_pkg::CoordW-1:0] sat_max, sat_min;
    assign sat_max = {1'b0, {(pps_pkg::CoordW - 1){1'b1}}};
    assign sat_min = {1'b1, {(pps_pkg::CoordW - 1){1'b0}}};

    `CHK_CLK(a_inv_zero, i_clk, i_rst_n, (i_out_valid && i_invalid) |-> (i_sx == '0 && i_sy == '0 && !i_overflow), "invalid word not zeroed")
    `CHK_CLK(a_ovf_excl, i_clk, i_rst_n, (i_out_valid && i_overflow) |-> !i_invalid, "overflow and invalid together")
    `CHK_CLK(a_ovf_sat, i_clk, i_rst_n, (i_out_valid && i_overflow) |-> (i_sx == sat_max || i_sx == sat_min || i_sy == sat_max || i_sy == sat_min), "overflow without saturated value")
    `CHK_CLK(a_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_sx) && $stable(i_sy)), "stalled word changed")
endmodule

bind perspective_project_screen_core pps_checker u_pps_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_out_valid(o_scr.valid),
    .i_out_ready(o_scr.ready),
    .i_sx       (o_scr.screen_x),
    .i_sy       (o_scr.screen_y),
    .i_invalid  (o_scr.invalid),
    .i_overflow (o_scr.overflow)
);

>>> verif/tb_ifs.sv
`timescale 1ns / 1ps
// Channel interfaces are provided by the RTL (src/pps_if.sv); nothing extra is needed here.
package tb_ifs_pkg;
    localparam int WatchdogLimit = 20000;
endpackage

>>> verif/tb.sv
`timescale 1ns / 1ps
module tb;
    typedef struct {
        pps_pkg::t_coord sx;
        pps_pkg::t_coord sy;
        logic            inv;
        logic            ovf;
    } t_screen;

    class projection_board;
        t_screen pending[$];
        int      errors;
        logic [pps_pkg::AspectW-1:0] aspect;
        logic [pps_pkg::TanW-1:0]    tanv;

        function new();
            errors = 0;
            aspect = pps_pkg::AspectRst;
            tanv   = pps_pkg::TanRst;
        endfunction

        function void note_point(pps_pkg::t_coord x, pps_pkg::t_coord y, pps_pkg::t_coord z);
            t_screen r;
            logic [31:0]  mz;
            logic [55:0]  s_mag;
            logic         sat;
            mz    = z[31] ? 32'(-z) : 32'(z);
            s_mag = 56'(mz) * 56'(tanv);
            sat   = 1'b0;
            if (s_mag <= 56'(pps_pkg::DeltaRaw)) begin
                r = '{0, 0, 1'b1, 1'b0};
            end else begin
                // sign of each result is its coordinate's sign xor the sign of z
                r.sx  = fix_sign(aspect, x, z, s_mag, sat);
                r.sy  = fix_sign(pps_pkg::AspectOne, y, z, s_mag, sat);
                r.inv = 1'b0;
                r.ovf = sat;
            end
            pending.push_back(r);
        endfunction

        function automatic logic [31:0] fix_sign(logic [15:0] scale, pps_pkg::t_coord v,
                                                 pps_pkg::t_coord z, logic [55:0] s_mag,
                                                 ref logic sat);
            logic [127:0] num;
            logic [127:0] q;
            logic [31:0]  m;
            logic         neg;
            m   = v[31] ? 32'(-v) : 32'(v);
            neg = v[31] ^ z[31];
            num = (128'(scale) * 128'(m)) << pps_pkg::NumShift;
            q   = num / 128'(s_mag);
            if (q == 0) return 32'd0;
            if (neg) begin
                if (q > 128'h8000_0000) begin
                    sat = 1'b1;
                    return 32'h8000_0000;
                end
                return 32'(-q[31:0]);
            end
            if (q > 128'h7fff_ffff) begin
                sat = 1'b1;
                return 32'h7fff_ffff;
            end
            return q[31:0];
        endfunction

        function void check_screen(pps_pkg::t_coord sx, pps_pkg::t_coord sy, logic inv,
                                   logic ovf);
            t_screen e;
            if (pending.size() == 0) begin
                $error("unexpected word sx=%h sy=%h", sx, sy);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (sx !== e.sx) begin
                $error("screen_x exp %h got %h", e.sx, sx);
                errors++;
            end
            if (sy !== e.sy) begin
                $error("screen_y exp %h got %h", e.sy, sy);
                errors++;
            end
            if (inv !== e.inv) begin
                $error("invalid exp %b got %b", e.inv, inv);
                errors++;
            end
            if (ovf !== e.ovf) begin
                $error("overflow exp %b got %b", e.ovf, ovf);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    pps_in_if  pt();
    pps_out_if scr();
    pps_cfg_if cfg();

    perspective_project_screen_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pt(pt.sink), .i_cfg(cfg.sink), .o_scr(scr.source)
    );

    projection_board board;
    int  idle_cycles;
    bit  hold_sink;
    bit  sink_mode_busy;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // sink side: random back-pressure plus one long hold-off
    initial begin
        int g;
        scr.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_sink) begin
                scr.ready <= 1'b0;
                repeat (300) @(negedge i_clk);
                hold_sink = 1'b0;
            end
            if (sink_mode_busy) begin
                g = gap_len();
                if (g > 0) begin
                    scr.ready <= 1'b0;
                    repeat (g) @(negedge i_clk);
                end
            end
            scr.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && scr.valid && scr.ready)
            board.check_screen(scr.screen_x, scr.screen_y, scr.invalid, scr.overflow);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (pt.valid && pt.ready) || (scr.valid && scr.ready) ||
            (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= tb_ifs_pkg::WatchdogLimit);
        $display("FAIL");
        $finish;
    end

    task automatic send_point(pps_pkg::t_coord x, pps_pkg::t_coord y, pps_pkg::t_coord z,
                              bit use_gaps);
        int g;
        if (use_gaps) begin
            g = gap_len();
            if (g > 0) begin
                pt.valid <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
        end
        pt.valid   <= 1'b1;
        pt.point_x <= x;
        pt.point_y <= y;
        pt.point_z <= z;
        @(posedge i_clk);
        while (!pt.ready) @(posedge i_clk);
        board.note_point(x, y, z);
        @(negedge i_clk);
    endtask

    task automatic drain();
        pt.valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (45) @(negedge i_clk);
    endtask

    task automatic write_reg(pps_pkg::t_cfg_reg idx, logic [pps_pkg::CfgDataW-1:0] d);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= d;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        if (idx == pps_pkg::REG_ASPECT) board.aspect = d[pps_pkg::AspectW-1:0];
        else board.tanv = d[pps_pkg::TanW-1:0];
        @(negedge i_clk);
        cfg.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic pps_pkg::t_coord rand_coord();
        case ($urandom_range(0, 5))
            0: return pps_pkg::t_coord'($urandom);
            1: return pps_pkg::t_coord'($urandom_range(0, 32'h0003_ffff)) *
                      ($urandom_range(0, 1) ? 1 : -1);
            2: return pps_pkg::t_coord'($urandom_range(0, 200));
            3: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return pps_pkg::t_coord'($urandom_range(0, 32'h0100_0000)) -
                            32'sh0080_0000;
        endcase
    endfunction

    initial begin
        pps_pkg::t_coord dx[$];
        logic [pps_pkg::AspectW-1:0] asp_set[5];
        logic [pps_pkg::TanW-1:0]    tan_set[5];
        board = new();
        hold_sink = 0;
        sink_mode_busy = 0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        pt.valid = 1'b0;
        pt.point_x = '0;
        pt.point_y = '0;
        pt.point_z = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset configuration, directed corners
        dx = '{32'sh7fff_ffff, 32'sh8000_0000, 0, 32'sh0001_0000, -32'sh0001_0000, 1, -1};
        foreach (dx[i]) send_point(dx[i], -dx[i], 32'sh0001_0000, 0);
        send_point(32'sh0001_0000, 32'sh0001_0000, 0, 0);          // depth zero
        send_point(32'sh0001_0000, 32'sh0001_0000, 65, 0);         // just below threshold
        send_point(32'sh0001_0000, 32'sh0001_0000, 66, 0);         // just above
        send_point(32'sh0001_0000, -32'sh0001_0000, -66, 0);
        send_point(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 0);
        send_point(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 0);
        send_point(32'sh4000_0000, -32'sh4000_0000, 67, 0);        // saturation both signs
        drain();
        write_reg(pps_pkg::REG_ASPECT, 0);                          // zero aspect
        write_reg(pps_pkg::REG_TAN, 0);                             // tangent zero -> invalid
        send_point(-32'sh0003_0000, 32'sh0002_0000, 32'sh0001_0000, 0);
        drain();
        write_reg(pps_pkg::REG_TAN, 24'hff_ffff);
        write_reg(pps_pkg::REG_ASPECT, 16'hffff);
        send_point(-32'sh0003_0000, 32'sh0002_0000, 1, 0);
        send_point(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 0);
        drain();

        asp_set = '{16'd256, 16'd0, 16'hffff, 16'd384, 16'd1};
        tan_set = '{24'h01_0000, 24'hff_ffff, 24'd1, 24'h00_93cd, 24'h00_0000};
        sink_mode_busy = 1;
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(pps_pkg::REG_ASPECT, ph < 5 ? asp_set[ph] : 16'($urandom));
            write_reg(pps_pkg::REG_TAN,
                      ph < 5 ? tan_set[ph] : 24'($urandom_range(1, 24'h04_0000)));
            if (ph == 2) hold_sink = 1;
            for (int n = 0; n < 160; n++)
                send_point(rand_coord(), rand_coord(), rand_coord(), ph != 2 && n > 20);
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+src
src/pps_pkg.sv
src/pps_if.sv
src/pps_front.sv
src/pps_div_step.sv
src/pps_back.sv
src/perspective_project_screen_core.sv
src/pps_checker.sv
verif/tb_ifs.sv
verif/tb.sv
